// ===== rtl/sc2c_pkg.sv =====
// Package for the scancode to character decoder: key codes, layout tables, decode function.
package sc2c_pkg;

  localparam int unsigned ScWidth   = 8;
  localparam int unsigned CharWidth = 7;
  localparam int unsigned MapDepth  = 58;
  localparam int unsigned MapIdxW   = $clog2(MapDepth);

  localparam logic [ScWidth-1:0] SC_LSHIFT_DN = 8'h2A;
  localparam logic [ScWidth-1:0] SC_RSHIFT_DN = 8'h36;
  localparam logic [ScWidth-1:0] SC_LSHIFT_UP = 8'hAA;
  localparam logic [ScWidth-1:0] SC_RSHIFT_UP = 8'hB6;
  localparam logic [ScWidth-1:0] SC_CTRL_DN   = 8'h1D;
  localparam logic [ScWidth-1:0] SC_CTRL_UP   = 8'h9D;
  localparam logic [ScWidth-1:0] SC_ESC       = 8'h01;
  localparam logic [ScWidth-1:0] SC_BKSP      = 8'h0E;
  localparam logic [ScWidth-1:0] SC_TAB       = 8'h0F;
  localparam logic [ScWidth-1:0] SC_ENTER     = 8'h1C;
  localparam logic [ScWidth-1:0] SC_UP        = 8'h48;
  localparam logic [ScWidth-1:0] SC_DOWN      = 8'h50;
  localparam logic [ScWidth-1:0] SC_LEFT      = 8'h4B;
  localparam logic [ScWidth-1:0] SC_RIGHT     = 8'h4D;
  localparam logic [ScWidth-1:0] SC_PGUP      = 8'h49;
  localparam logic [ScWidth-1:0] SC_PGDN      = 8'h51;
  localparam logic [ScWidth-1:0] SC_HOME      = 8'h47;
  localparam logic [ScWidth-1:0] SC_END       = 8'h4F;
  localparam logic [ScWidth-1:0] SC_TABLE_LAST = 8'h39;

  localparam logic [CharWidth-1:0] CH_NONE  = 7'h00;
  localparam logic [CharWidth-1:0] CH_LOW_A = 7'h61;
  localparam logic [CharWidth-1:0] CH_LOW_Z = 7'h7A;
  localparam logic [CharWidth-1:0] CH_UP_A  = 7'h41;
  localparam logic [CharWidth-1:0] CH_UP_Z  = 7'h5A;
  localparam logic [CharWidth-1:0] CH_LOW_BASE = 7'h60;
  localparam logic [CharWidth-1:0] CH_UP_BASE  = 7'h40;

  // AZERTY layout, unshifted
  localparam logic [CharWidth-1:0] PLAIN_MAP [MapDepth] = '{
    7'h00, 7'h1B, 7'h26, 7'h65, 7'h22, 7'h27, 7'h28, 7'h2D,
    7'h65, 7'h5F, 7'h63, 7'h61, 7'h29, 7'h3D, 7'h08, 7'h09,
    7'h61, 7'h7A, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5E, 7'h24, 7'h0A, 7'h00, 7'h71, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h6D,
    7'h75, 7'h2A, 7'h00, 7'h2A, 7'h77, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h2C, 7'h3B, 7'h3A, 7'h21, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  // AZERTY layout, shifted
  localparam logic [CharWidth-1:0] SHIFT_MAP [MapDepth] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2B, 7'h3D, 7'h08, 7'h09,
    7'h41, 7'h5A, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h51, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h4D,
    7'h25, 7'h7E, 7'h00, 7'h23, 7'h57, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h3F, 7'h2E, 7'h2F, 7'h73, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 shift_held;
    logic                 ctrl_held;
  } dec_res_t;

  function automatic logic [CharWidth-1:0] fixed_key(input logic [ScWidth-1:0] sc);
    logic [CharWidth-1:0] c;
    unique case (sc)
      SC_ESC:   c = 7'd27;
      SC_BKSP:  c = 7'd8;
      SC_TAB:   c = 7'd9;
      SC_ENTER: c = 7'd10;
      SC_UP:    c = 7'd16;
      SC_DOWN:  c = 7'd14;
      SC_LEFT:  c = 7'd17;
      SC_RIGHT: c = 7'd18;
      SC_PGUP:  c = 7'd11;
      SC_PGDN:  c = 7'd12;
      SC_HOME:  c = 7'd2;
      SC_END:   c = 7'd3;
      default:  c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic dec_res_t decode(input logic [ScWidth-1:0] sc,
                                      input logic shift_in,
                                      input logic ctrl_in);
    dec_res_t             r;
    logic [CharWidth-1:0] fk;
    logic [CharWidth-1:0] mc;
    logic [MapIdxW-1:0]   idx;
    fk  = fixed_key(sc);
    idx = sc[MapIdxW-1:0];
    mc  = shift_in ? SHIFT_MAP[idx] : PLAIN_MAP[idx];
    r.char_code  = CH_NONE;
    r.shift_held = shift_in;
    r.ctrl_held  = ctrl_in;
    priority if (sc == SC_LSHIFT_UP || sc == SC_RSHIFT_UP) begin
      r.shift_held = 1'b0;
    end else if (sc == SC_CTRL_UP) begin
      r.ctrl_held = 1'b0;
    end else if (sc[ScWidth-1]) begin
      r.char_code = CH_NONE;
    end else if (sc == SC_LSHIFT_DN || sc == SC_RSHIFT_DN) begin
      r.shift_held = 1'b1;
    end else if (sc == SC_CTRL_DN) begin
      r.ctrl_held = 1'b1;
    end else if (fk != CH_NONE) begin
      r.char_code = fk;
    end else if (sc > SC_TABLE_LAST) begin
      r.char_code = CH_NONE;
    end else if (ctrl_in && mc != CH_NONE) begin
      r.ctrl_held = 1'b0;
      if (mc >= CH_LOW_A && mc <= CH_LOW_Z) begin
        r.char_code = mc - CH_LOW_BASE;
      end else if (mc >= CH_UP_A && mc <= CH_UP_Z) begin
        r.char_code = mc - CH_UP_BASE;
      end else begin
        r.char_code = CH_NONE;
      end
    end else begin
      r.char_code = mc;
    end
    return r;
  endfunction

endpackage

// ===== rtl/scancode_to_char_decoder_unit.sv =====
// Scancode set 1 to AZERTY character decoder, top level.
// Takes one raw set-1 scancode byte per beat and returns one result beat per
// scancode: the character (0 for none) and the shift and ctrl flags after it.
// Two register stages: an input register and a result register, with the table
// lookup and modifier update between them. One beat per cycle is sustained
// while out_tready is high; each scancode passes the input register and then
// the result register. The modifier flags are updated as each scancode leaves
// the input register, so back-to-back scancodes see the flags left by the one before.
module scancode_to_char_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scancode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [6:0] char_code, [7] shift_held, [8] ctrl_held, zero pad
);
  import sc2c_pkg::*;

  logic               in_vld_r;
  logic [ScWidth-1:0] sc_r;
  logic               out_vld_r;
  dec_res_t           res_r;
  logic               shift_r;
  logic               ctrl_r;
  dec_res_t           res_nxt;
  logic               adv;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign res_nxt   = decode(sc_r, shift_r, ctrl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      shift_r   <= 1'b0;
      ctrl_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        shift_r   <= res_nxt.shift_held;
        ctrl_r    <= res_nxt.ctrl_held;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sc_r <= in_tdata;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, res_r.ctrl_held, res_r.shift_held, res_r.char_code};

endmodule
